@@ rtl/core/spms_pkg.sv @@
// Shared constants and types for the shared-pool multi-stack.
package spms_pkg;

  // Sizing
  localparam int NUM_STACKS = 4;
  localparam int POOL_SIZE  = 16;
  localparam int VALUE_W    = 32;

  // Link holds an entry index or the null code POOL_SIZE
  localparam int LINK_W = $clog2(POOL_SIZE + 1);
  localparam int ADDR_W = $clog2(POOL_SIZE);
  localparam int SID_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

  typedef logic [LINK_W-1:0] link_t;

  // Request opcodes
  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

endpackage

@@ rtl/core/spms_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module spms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/shared_pool_multi_stack.sv @@
// Top level: several LIFO stacks sharing one linked pool with a free list.
//
//  channel  | ports                                      | flow
//  ---------+--------------------------------------------+-------------------------------
//  request  | start, busy, in_func, in_stack_id,         | taken when start && !busy
//           | in_push_value                              |
//  result   | out_valid, out_status, out_pop_value       | one-cycle strobe, no backpressure
//
// Each request has an accept cycle, which reads the link and value memories,
// and a write-back cycle after it, which modifies the heads and writes the link
// entry back. The result strobe comes in the cycle after that, and a new request
// may be accepted in that same cycle, while the previous result is shown.
// Reset is synchronous; link entries not yet written read as their reset
// chain through per-entry valid bits, so no clearing pass is needed.
// The receiver cannot stall; busy is high only in the write-back cycle.
module shared_pool_multi_stack import spms_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_func,
  input  logic [1:0]         in_stack_id,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_pop_value
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t               state_r;
  logic                 func_r;
  logic [SID_W-1:0]     sid_r;
  logic [VALUE_W-1:0]   val_r;
  logic [ADDR_W-1:0]    slot_r;
  logic                 err_r;
  link_t                free_head_r;
  link_t                head_r [NUM_STACKS];
  logic [POOL_SIZE-1:0] link_vld_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [VALUE_W-1:0]   out_pop_value_r;

  logic                 accept;
  logic                 exec;
  logic [SID_W-1:0]     sid_ext;
  logic                 sid_ok;
  link_t                rd_link;
  logic                 req_err;
  logic [ADDR_W-1:0]    rd_addr;
  link_t                link_rdata;
  logic [VALUE_W-1:0]   val_rdata;
  link_t                link_q;
  logic                 push_ok;
  logic                 pop_ok;
  logic                 link_we;
  link_t                link_wdata;
  logic [1:0]           status_nxt;
  logic [VALUE_W-1:0]   pop_value_nxt;

  // Handshake
  assign exec   = (state_r == S_EXEC);
  assign busy   = exec;
  assign accept = start && !busy;

  // Read address: stack top for a pop, free-list head for a push
  assign sid_ext = SID_W'(in_stack_id);
  assign sid_ok  = (int'(in_stack_id) < NUM_STACKS);
  assign rd_link = (in_func == FUNC_POP) ? head_r[sid_ext] : free_head_r;
  assign req_err = !sid_ok || (rd_link >= link_t'(POOL_SIZE));
  assign rd_addr = rd_link[ADDR_W-1:0];

  // Link data: unwritten entries follow the reset chain
  assign link_q = link_vld_r[slot_r] ? link_rdata : (link_t'(slot_r) + link_t'(1));

  // Write-back decode
  assign push_ok    = exec && (func_r == FUNC_PUSH) && !err_r;
  assign pop_ok     = exec && (func_r == FUNC_POP) && !err_r;
  assign link_we    = push_ok || pop_ok;
  assign link_wdata = push_ok ? head_r[sid_r] : free_head_r;

  // Result
  always_comb begin
    if (!err_r) begin
      status_nxt = STATUS_OK;
    end else if (func_r == FUNC_PUSH) begin
      status_nxt = STATUS_FULL;
    end else begin
      status_nxt = STATUS_EMPTY;
    end
  end
  assign pop_value_nxt = pop_ok ? val_rdata : '0;

  // Memories
  spms_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_SIZE)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (slot_r),
    .wdata (link_wdata),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  spms_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (POOL_SIZE)
  ) u_value_ram (
    .clk   (clk),
    .we    (push_ok),
    .waddr (slot_r),
    .wdata (val_r),
    .raddr (rd_addr),
    .rdata (val_rdata)
  );

  // Control state, heads and registered result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      err_r        <= 1'b0;
      free_head_r  <= '0;
      link_vld_r   <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= STATUS_OK;
      for (int i = 0; i < NUM_STACKS; i++) begin
        head_r[i] <= link_t'(POOL_SIZE);
      end
    end else begin
      out_valid_r <= exec;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
            err_r   <= req_err;
          end
        end
        S_EXEC: begin
          state_r      <= S_IDLE;
          out_status_r <= status_nxt;
          if (push_ok) begin
            free_head_r   <= link_q;
            head_r[sid_r] <= link_t'(slot_r);
          end
          if (pop_ok) begin
            head_r[sid_r] <= link_q;
            free_head_r   <= link_t'(slot_r);
          end
          if (link_we) begin
            link_vld_r[slot_r] <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Request payload and result value
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      sid_r  <= sid_ext;
      val_r  <= in_push_value;
      slot_r <= rd_addr;
    end
    if (exec) begin
      out_pop_value_r <= pop_value_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_pop_value = out_pop_value_r;

`ifndef SYNTHESIS
  // An accepted request always occupies the write-back cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter write-back");

  // Every write-back produces exactly one result strobe
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("write-back not followed by a result");

  // Failed requests return a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STATUS_OK)) |-> (out_pop_value == '0))
    else $error("failed request returned a nonzero value");

  // A successful push leaves the free-list head off the pushed entry
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |=> (free_head_r != link_t'($past(slot_r))))
    else $error("pushed entry still at free-list head");
`endif

endmodule

@@ tb/shared_pool_multi_stack_test.sv @@
// Testbench for the shared-pool multi-stack: directed table, then random push/pop traffic.
`timescale 1ns / 1ps

module shared_pool_multi_stack_test;
  import spms_pkg::*;

  localparam int NUM_RANDOM  = 700;
  localparam int CYCLE_LIMIT = 100000;
  localparam int NUM_ROWS    = 25;

  // One expected result
  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] pop_value;
  } stack_result_t;

  // One row of the directed table; typed rows carry their own expectation
  typedef struct packed {
    func_t              func;
    logic [1:0]         sid;
    logic [VALUE_W-1:0] value;
    logic               typed;
    status_t            status;
    logic [VALUE_W-1:0] pop_value;
  } request_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_func;
  logic [1:0]         in_stack_id;
  logic signed [31:0] in_push_value;
  logic               out_valid;
  logic [1:0]         out_status;
  logic signed [31:0] out_pop_value;

  shared_pool_multi_stack dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_stack_id   (in_stack_id),
    .in_push_value (in_push_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_pop_value (out_pop_value)
  );

  // Shadow copy of the pool
  logic [VALUE_W-1:0] pool_value [POOL_SIZE];
  link_t              pool_link  [POOL_SIZE];
  link_t              stack_top  [NUM_STACKS];
  link_t              free_top;

  stack_result_t pending_results[$];
  int            error_count;
  int            cycle_count;
  int            push_count;
  int            pop_count;
  int            full_count;
  int            empty_count;
  bit            idle_on;

  // Directed requests: empty pops, extremes on stack 0, fill the pool, overflow
  request_row_t directed_rows [NUM_ROWS] = '{
    '{FUNC_POP,  2'd1, 32'h0000_0000, 1'b1, STATUS_EMPTY, 32'h0},
    '{FUNC_POP,  2'd2, 32'hFFFF_FFFF, 1'b1, STATUS_EMPTY, 32'h0},
    '{FUNC_POP,  2'd3, 32'h0000_0000, 1'b1, STATUS_EMPTY, 32'h0},
    '{FUNC_PUSH, 2'd0, 32'h7FFF_FFFF, 1'b1, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd0, 32'h8000_0000, 1'b1, STATUS_OK,    32'h0},
    '{FUNC_POP,  2'd0, 32'h1234_5678, 1'b1, STATUS_OK,    32'h8000_0000},
    '{FUNC_POP,  2'd0, 32'h0000_0000, 1'b1, STATUS_OK,    32'h7FFF_FFFF},
    '{FUNC_POP,  2'd0, 32'h0000_0000, 1'b1, STATUS_EMPTY, 32'h0},
    '{FUNC_PUSH, 2'd0, 32'h0000_0000, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd1, 32'hFFFF_FFFF, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd2, 32'h5555_5555, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd3, 32'hAAAA_AAAA, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd0, 32'h0000_0001, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd1, 32'h8000_0000, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd2, 32'h7FFF_FFFF, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd3, 32'hDEAD_BEEF, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd3, 32'h0F0F_0F0F, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd3, 32'hF0F0_F0F0, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd0, 32'h3333_3333, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd1, 32'hCCCC_CCCC, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd2, 32'h0000_FFFF, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd0, 32'hFFFF_0000, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd1, 32'h0000_0002, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd3, 32'hFFFF_FFFE, 1'b0, STATUS_OK,    32'h0},
    '{FUNC_PUSH, 2'd2, 32'h0BAD_F00D, 1'b1, STATUS_FULL,  32'h0}
  };

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Reset state of the pool: free list chains every entry in order
  task automatic clear_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_value[i] = '0;
      pool_link[i]  = link_t'(i + 1);
    end
    for (int s = 0; s < NUM_STACKS; s++) stack_top[s] = link_t'(POOL_SIZE);
    free_top = '0;
  endtask

  // Apply one request to the shadow pool and return the result it produces
  function automatic stack_result_t apply_to_pool(func_t op, logic [1:0] sid,
                                                  logic [VALUE_W-1:0] value);
    stack_result_t     res;
    logic [ADDR_W-1:0] slot;
    res.status    = STATUS_OK;
    res.pop_value = '0;
    if (op == FUNC_PUSH) begin
      if (int'(sid) >= NUM_STACKS || int'(free_top) >= POOL_SIZE) begin
        res.status = STATUS_FULL;
      end else begin
        slot            = free_top[ADDR_W-1:0];
        free_top        = pool_link[slot];
        pool_value[slot] = value;
        pool_link[slot] = stack_top[sid];
        stack_top[sid]  = link_t'(slot);
      end
    end else begin
      if (int'(sid) >= NUM_STACKS || int'(stack_top[sid]) >= POOL_SIZE) begin
        res.status = STATUS_EMPTY;
      end else begin
        slot            = stack_top[sid][ADDR_W-1:0];
        stack_top[sid]  = pool_link[slot];
        pool_link[slot] = free_top;
        free_top        = link_t'(slot);
        res.pop_value   = pool_value[slot];
      end
    end
    return res;
  endfunction

  // Issue one request; called just after a falling edge, returns just after a falling edge once the request is accepted
  task automatic issue_request(func_t op, logic [1:0] sid, logic [VALUE_W-1:0] value,
                               logic typed, stack_result_t typed_result);
    stack_result_t predicted;
    while (idle_on && $urandom_range(99) < 32) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_func       <= op;
    in_stack_id   <= sid;
    in_push_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    predicted = apply_to_pool(op, sid, value);
    pending_results.push_back(typed ? typed_result : predicted);
    if (op == FUNC_PUSH) push_count++;
    else pop_count++;
    @(negedge clk);
  endtask

  // Compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    stack_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d pop_value %h", out_status, out_pop_value);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_status);
          error_count++;
        end
        if (out_pop_value !== exp_res.pop_value) begin
          $error("pop_value: expected %h, got %h", exp_res.pop_value, out_pop_value);
          error_count++;
        end
        if (exp_res.status == STATUS_FULL) full_count++;
        if (exp_res.status == STATUS_EMPTY) empty_count++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus
  initial begin
    stack_result_t      typed_result;
    func_t              op;
    logic [1:0]         sid;
    logic [VALUE_W-1:0] value;
    int                 push_bias;
    int                 drain_wait;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_func       = FUNC_PUSH;
    in_stack_id   = '0;
    in_push_value = '0;
    error_count   = 0;
    cycle_count   = 0;
    push_count    = 0;
    pop_count     = 0;
    full_count    = 0;
    empty_count   = 0;
    idle_on       = 1'b1;
    push_bias     = 50;
    clear_pool();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    foreach (directed_rows[i]) begin
      typed_result.status    = directed_rows[i].status;
      typed_result.pop_value = directed_rows[i].pop_value;
      issue_request(directed_rows[i].func, directed_rows[i].sid, directed_rows[i].value,
                    directed_rows[i].typed, typed_result);
    end

    // Random traffic in phases that fill, drain or churn the pool
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 30 == 0) begin
        case ($urandom_range(2))
          0: begin
            push_bias = 85;
          end
          1: begin
            push_bias = 15;
          end
          default: begin
            push_bias = 50;
          end
        endcase
      end
      idle_on = !(n >= 250 && n < 400);
      op  = ($urandom_range(99) < push_bias) ? FUNC_PUSH : FUNC_POP;
      sid = 2'($urandom_range(NUM_STACKS - 1));
      case ($urandom_range(7))
        0: begin
          value = 32'h7FFF_FFFF;
        end
        1: begin
          value = 32'h8000_0000;
        end
        2: begin
          value = ($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
        end
        default: begin
          value = $urandom;
        end
      endcase
      typed_result = '0;
      issue_request(op, sid, value, 1'b0, typed_result);
    end
    start <= 1'b0;

    // Drain, then wait for any stray strobes
    while (pending_results.size() != 0) @(posedge clk);
    drain_wait = 4;
    repeat (drain_wait) @(posedge clk);

    $display("Sent %0d pushes and %0d pops over %0d stacks sharing %0d entries;",
             push_count, pop_count, NUM_STACKS, POOL_SIZE);
    $display("saw %0d pool-full and %0d stack-empty responses, %0d errors.",
             full_count, empty_count, error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/spms_pkg.sv
rtl/core/spms_ram.sv
rtl/core/shared_pool_multi_stack.sv
tb/shared_pool_multi_stack_test.sv
